>>> hdl/bthe_pkg.sv
// Shared types and constants for the BER tag and length header encoder.
package bthe_pkg;

    // Request command codes
    localparam logic [1:0] CMD_DEFINITE   = 2'd0;
    localparam logic [1:0] CMD_INDEFINITE = 2'd1;
    localparam logic [1:0] CMD_EOC        = 2'd2;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    // Octet constants
    localparam logic [4:0] TAG_LONG_MARK = 5'h1F;
    localparam logic [7:0] HIGH_BIT      = 8'h80;
    localparam logic [7:0] EOC_OCTET     = 8'h00;

    // Field widths
    localparam int unsigned NUM_W  = 31;
    localparam int unsigned WORK_W = 35;
    localparam int unsigned CNT_W  = 3;

    // Digit counts at the start of normalisation
    localparam logic [CNT_W-1:0] TAG_DIGITS_MAX = 3'd5;
    localparam logic [CNT_W-1:0] LEN_BYTES_MAX  = 3'd4;

    // Operations of the shared shift unit
    typedef enum logic [2:0] {
        SH_HOLD,
        SH_LOAD_TAG,
        SH_LOAD_LEN,
        SH_SHL7,
        SH_SHL8
    } shift_op_t;

    typedef struct packed {
        shift_op_t        op;
        logic [NUM_W-1:0] operand;
    } shift_ctl_t;

    typedef struct packed {
        logic [6:0] top_digit;
        logic [7:0] top_octet;
        logic [4:0] tag_low;
        logic       tag_short;
    } shift_flags_t;

endpackage

>>> hdl/bthe_if.sv
// Handshake channels: header request in, encoded octet out.
interface bthe_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [1:0]  id_class;
    logic        constructed;
    logic [30:0] tag_number;
    logic [30:0] content_length;

    modport source (
        output valid, command, id_class, constructed, tag_number, content_length,
        input  ready
    );
    modport sink (
        input  valid, command, id_class, constructed, tag_number, content_length,
        output ready
    );
endinterface

interface bthe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (
        output valid, out_byte, last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last,
        output ready
    );
endinterface

>>> hdl/ber_tag_length_header_encoder.sv
// Top level of the BER identifier and length octet encoder.
// Usage:
//   hdr_in  takes one header request (command, class, form, tag number,
//           content length). oct_out gives the encoded octets one per item,
//           with last set on the final octet of the request.
//   Command 0 yields identifier plus definite length, command 1 identifier
//   plus 0x80, command 2 two zero octets, command 3 is taken and dropped.
// Operation:
//   A small sequencer drives one shared shift register that first walks the
//   tag number in 7-bit digits and then the content length in octets. Leading
//   zero digits are skipped one per cycle before each field is emitted, then
//   one octet is produced per cycle while oct_out takes them. After acceptance
//   the identifier (or first end-of-contents) state loads the first octet
//   into the output register. hdr_in is ready only while the sequencer is idle.
// Reset: sequencer returns to idle and the output register empties.
// Stall: when oct_out is not taken the octet is held and the sequencer
//   waits; no octet is lost or repeated.
module ber_tag_length_header_encoder (
    input  logic        clk,
    input  logic        rst_n,
    bthe_req_if.sink    hdr_in,
    bthe_byte_if.source oct_out
);
    import bthe_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ID_HEAD   = 4'd1;
    localparam logic [3:0] S_TAG_NORM  = 4'd2;
    localparam logic [3:0] S_TAG_DIGIT = 4'd3;
    localparam logic [3:0] S_LEN_START = 4'd4;
    localparam logic [3:0] S_LEN_NORM  = 4'd5;
    localparam logic [3:0] S_LEN_COUNT = 4'd6;
    localparam logic [3:0] S_LEN_BYTE  = 4'd7;
    localparam logic [3:0] S_EOC0      = 4'd8;
    localparam logic [3:0] S_EOC1      = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       cmd_reg;
    logic [1:0]       cls_reg;
    logic             form_reg;
    logic [NUM_W-1:0] len_reg;

    shift_ctl_t   sh_ctl;
    shift_flags_t sh_flags;

    logic       out_load;
    logic [7:0] out_byte_d;
    logic       out_last_d;
    logic       out_free;
    logic       accept;

    assign hdr_in.ready = (state_reg == S_IDLE);
    assign accept       = hdr_in.valid && hdr_in.ready;

    bthe_shift_unit u_shift (
        .clk   (clk),
        .ctl   (sh_ctl),
        .flags (sh_flags)
    );

    bthe_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_byte (out_byte_d),
        .load_last (out_last_d),
        .free      (out_free),
        .oct_out   (oct_out)
    );

    // Sequencer: pick the next octet, the shift operation and the next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sh_ctl.op      = SH_HOLD;
        sh_ctl.operand = len_reg;
        out_load       = 1'b0;
        out_byte_d     = EOC_OCTET;
        out_last_d     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next       = TAG_DIGITS_MAX;
                    sh_ctl.op      = SH_LOAD_TAG;
                    sh_ctl.operand = hdr_in.tag_number;
                    priority case (hdr_in.command)
                        CMD_EOC:    state_next = S_EOC0;
                        CMD_UNUSED: state_next = S_IDLE;
                        default:    state_next = S_ID_HEAD;
                    endcase
                end
            end
            S_ID_HEAD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_byte_d = {cls_reg, form_reg,
                                  sh_flags.tag_short ? sh_flags.tag_low : TAG_LONG_MARK};
                    state_next = sh_flags.tag_short ? S_LEN_START : S_TAG_NORM;
                end
            end
            S_TAG_NORM:
            begin
                // Drop leading zero digits
                if ((sh_flags.top_digit == 7'd0) && (cnt_reg > 3'd1))
                begin
                    sh_ctl.op = SH_SHL7;
                    cnt_next  = cnt_reg - 3'd1;
                end
                else
                begin
                    state_next = S_TAG_DIGIT;
                end
            end
            S_TAG_DIGIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_byte_d = {(cnt_reg > 3'd1), sh_flags.top_digit};
                    sh_ctl.op  = SH_SHL7;
                    cnt_next   = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd1)
                    begin
                        state_next = S_LEN_START;
                    end
                end
            end
            S_LEN_START:
            begin
                if (cmd_reg == CMD_INDEFINITE)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        out_byte_d = HIGH_BIT;
                        out_last_d = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (len_reg[NUM_W-1:7] == '0)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        out_byte_d = {1'b0, len_reg[6:0]};
                        out_last_d = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    sh_ctl.op  = SH_LOAD_LEN;
                    cnt_next   = LEN_BYTES_MAX;
                    state_next = S_LEN_NORM;
                end
            end
            S_LEN_NORM:
            begin
                // Drop leading zero octets
                if ((sh_flags.top_octet == 8'd0) && (cnt_reg > 3'd1))
                begin
                    sh_ctl.op = SH_SHL8;
                    cnt_next  = cnt_reg - 3'd1;
                end
                else
                begin
                    state_next = S_LEN_COUNT;
                end
            end
            S_LEN_COUNT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_byte_d = HIGH_BIT | {5'b0, cnt_reg};
                    state_next = S_LEN_BYTE;
                end
            end
            S_LEN_BYTE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_byte_d = sh_flags.top_octet;
                    out_last_d = (cnt_reg == 3'd1);
                    sh_ctl.op  = SH_SHL8;
                    cnt_next   = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EOC0:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_EOC1;
                end
            end
            S_EOC1:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_last_d = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold the request fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= hdr_in.command;
            cls_reg  <= hdr_in.id_class;
            form_reg <= hdr_in.constructed;
            len_reg  <= hdr_in.content_length;
        end
    end

    // Emission states never run with an exhausted digit count
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAG_DIGIT || state_reg == S_LEN_BYTE) |-> (cnt_reg != '0))
        else $error("digit count exhausted while emitting");

    // The output register is only loaded when it is empty or being drained
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!oct_out.valid || oct_out.ready))
        else $error("output item overwritten");

    // A request that yields octets keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_in.valid && hdr_in.ready && hdr_in.command != CMD_UNUSED) |=> !hdr_in.ready)
        else $error("request accepted while busy");

endmodule

>>> hdl/bthe_shift_unit.sv
// Shared work register with left shifts by one base-128 digit or one octet.
module bthe_shift_unit (
    input  logic                  clk,
    input  bthe_pkg::shift_ctl_t  ctl,
    output bthe_pkg::shift_flags_t flags
);
    import bthe_pkg::*;

    logic [WORK_W-1:0] work_reg;
    logic [WORK_W-1:0] work_next;

    // Select load, shift or hold
    always_comb
    begin
        unique case (ctl.op)
            SH_LOAD_TAG: work_next = {4'b0, ctl.operand};
            SH_LOAD_LEN: work_next = {1'b0, ctl.operand, 3'b0};
            SH_SHL7:     work_next = {work_reg[WORK_W-8:0], 7'b0};
            SH_SHL8:     work_next = {work_reg[WORK_W-9:0], 8'b0};
            default:     work_next = work_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    // Report the leading digit, leading octet and short-tag test
    always_comb
    begin
        flags.top_digit = work_reg[WORK_W-1 -: 7];
        flags.top_octet = work_reg[WORK_W-1 -: 8];
        flags.tag_low   = work_reg[4:0];
        flags.tag_short = (work_reg[WORK_W-1:5] == '0) && (work_reg[4:0] != TAG_LONG_MARK);
    end

endmodule

>>> hdl/bthe_out_stage.sv
// Output register for encoded octets; frees up when the receiver takes the item.
module bthe_out_stage (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [7:0]  load_byte,
    input  logic        load_last,
    output logic        free,
    bthe_byte_if.source oct_out
);
    import bthe_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign free = !valid_reg || oct_out.ready;

    // Hold the item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (oct_out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= load_byte;
            last_reg <= load_last;
        end
    end

    assign oct_out.valid    = valid_reg;
    assign oct_out.out_byte = byte_reg;
    assign oct_out.last     = last_reg;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the BER identifier and length octet encoder.
module testbench;
    import bthe_pkg::*;

    localparam logic [30:0] TAG_SHORT_LIMIT = 31'd31;
    localparam logic [30:0] LEN_SHORT_LIMIT = 31'd128;
    localparam int          RANDOM_REQS     = 360;
    localparam int          HOLD_AT_OCTET   = 500;
    localparam int          HOLD_CYCLES     = 400;

    typedef struct {
        logic [1:0]  command;
        logic [1:0]  id_class;
        logic        constructed;
        logic [30:0] tag_number;
        logic [30:0] content_length;
    } hdr_req_t;

    typedef struct {
        logic [7:0] octet;
        logic       last;
    } ber_octet_t;

    logic clk;
    logic rst_n;

    bthe_req_if  req_ch ();
    bthe_byte_if oct_ch ();

    ber_tag_length_header_encoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .hdr_in  (req_ch),
        .oct_out (oct_ch)
    );

    hdr_req_t   pending_reqs [$];
    ber_octet_t octets_expected [$];

    int reqs_taken;
    int req_wait;
    int octet_wait;
    int octets_seen;
    int mismatches;
    int hold_left;
    bit hold_armed;

    // Work out the octets that one request must produce, in order
    function automatic void encode_header(input hdr_req_t r);
        logic [7:0]  octs [$];
        logic [7:0]  lead;
        logic [30:0] rest;
        int          n;
        ber_octet_t  o;
        lead = {r.id_class, r.constructed, 5'd0};
        if (r.command == CMD_DEFINITE || r.command == CMD_INDEFINITE)
        begin
            // Identifier: short form, or long mark plus base-128 digits
            if (r.tag_number < TAG_SHORT_LIMIT)
            begin
                octs.push_back(lead | {3'd0, r.tag_number[4:0]});
            end
            else
            begin
                octs.push_back(lead | {3'd0, TAG_LONG_MARK});
                n = 0;
                rest = r.tag_number;
                while (rest != 0)
                begin
                    n++;
                    rest = rest >> 7;
                end
                for (int i = n - 1; i >= 0; i--)
                begin
                    rest = r.tag_number >> (7 * i);
                    octs.push_back({i != 0, rest[6:0]});
                end
            end
            // Length: definite short or long form, else the indefinite marker
            if (r.command == CMD_DEFINITE)
            begin
                if (r.content_length < LEN_SHORT_LIMIT)
                begin
                    octs.push_back(r.content_length[7:0]);
                end
                else
                begin
                    n = 0;
                    rest = r.content_length;
                    while (rest != 0)
                    begin
                        n++;
                        rest = rest >> 8;
                    end
                    octs.push_back(HIGH_BIT | 8'(n));
                    for (int i = n - 1; i >= 0; i--)
                    begin
                        rest = r.content_length >> (8 * i);
                        octs.push_back(rest[7:0]);
                    end
                end
            end
            else
            begin
                octs.push_back(HIGH_BIT);
            end
        end
        else if (r.command == CMD_EOC)
        begin
            octs.push_back(EOC_OCTET);
            octs.push_back(EOC_OCTET);
        end
        // Unused command: nothing comes out
        for (int k = 0; k < octs.size(); k++)
        begin
            o.octet = octs[k];
            o.last  = (k == octs.size() - 1);
            octets_expected.push_back(o);
        end
    endfunction

    task automatic add_req(input logic [1:0] command, input logic [1:0] id_class,
                           input logic constructed, input logic [30:0] tag_number,
                           input logic [30:0] content_length);
        hdr_req_t r;
        r.command        = command;
        r.id_class       = id_class;
        r.constructed    = constructed;
        r.tag_number     = tag_number;
        r.content_length = content_length;
        pending_reqs.push_back(r);
    endtask

    // Draw a number: a short-form value now and then, else a random bit width
    function automatic logic [30:0] random_number(input int short_max);
        int          w;
        logic [31:0] mask;
        if ($urandom_range(0, 3) == 0)
            return 31'($urandom_range(0, short_max));
        w = $urandom_range(1, 31);
        mask = (32'd1 << w) - 32'd1;
        return 31'($urandom & mask);
    endfunction

    // Clock, and known values on every input from time zero
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_DEFINITE;
        req_ch.id_class = 2'd0;
        req_ch.constructed = 1'b0;
        req_ch.tag_number = 31'd0;
        req_ch.content_length = 31'd0;
        oct_ch.ready = 1'b0;
        forever #10 clk = ~clk;
    end

    // Request driver: present queued items, idle a random count after each
    always @(posedge clk)
    begin : req_driver
        hdr_req_t taken;
        hdr_req_t next_req;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_wait = 0;
            reqs_taken = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken.command        = req_ch.command;
                taken.id_class       = req_ch.id_class;
                taken.constructed    = req_ch.constructed;
                taken.tag_number     = req_ch.tag_number;
                taken.content_length = req_ch.content_length;
                encode_header(taken);
                reqs_taken++;
                // Every so often run a stretch back to back
                req_wait = ((reqs_taken % 120) < 30) ? 0 : $urandom_range(0, 7);
            end
            else if (!req_ch.valid && req_wait > 0)
            begin
                req_wait--;
            end

            if (req_ch.valid && !req_ch.ready)
            begin
                // hold the item until it is taken
            end
            else if (req_wait == 0 && pending_reqs.size() != 0)
            begin
                next_req = pending_reqs.pop_front();
                req_ch.valid          <= 1'b1;
                req_ch.command        <= next_req.command;
                req_ch.id_class       <= next_req.id_class;
                req_ch.constructed    <= next_req.constructed;
                req_ch.tag_number     <= next_req.tag_number;
                req_ch.content_length <= next_req.content_length;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, so the encoder fills and stalls its input
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && octets_seen >= HOLD_AT_OCTET)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Octet monitor: compare each taken item with the oldest expectation
    always @(posedge clk)
    begin : octet_monitor
        ber_octet_t exp_oct;
        if (!rst_n)
        begin
            oct_ch.ready <= 1'b0;
            octet_wait = 0;
            octets_seen <= 0;
            mismatches = 0;
        end
        else
        begin
            if (oct_ch.valid && oct_ch.ready)
            begin
                octets_seen <= octets_seen + 1;
                if (octets_expected.size() == 0)
                begin
                    $error("octet 0x%02h last=%0b with no request pending",
                           oct_ch.out_byte, oct_ch.last);
                    mismatches++;
                end
                else
                begin
                    exp_oct = octets_expected.pop_front();
                    if (oct_ch.out_byte !== exp_oct.octet)
                    begin
                        $error("out_byte: expected 0x%02h, got 0x%02h",
                               exp_oct.octet, oct_ch.out_byte);
                        mismatches++;
                    end
                    if (oct_ch.last !== exp_oct.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_oct.last, oct_ch.last);
                        mismatches++;
                    end
                end
                octet_wait = ((octets_seen % 300) < 80) ? 0 : $urandom_range(0, 7);
            end
            else if (octet_wait > 0)
            begin
                octet_wait--;
            end
            oct_ch.ready <= (octet_wait == 0) && (hold_left == 0);
        end
    end

    // Stimulus, reset release and end of run
    initial
    begin : stimulus
        int       made;
        int       pick;
        hdr_req_t r;

        // Directed: field extremes, every command, both identifier and length forms
        add_req(CMD_EOC, 2'd3, 1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_req(CMD_UNUSED, 2'd2, 1'b1, 31'd40, 31'd300);
        add_req(CMD_DEFINITE, 2'd0, 1'b0, 31'd0, 31'd0);
        add_req(CMD_DEFINITE, 2'd1, 1'b1, 31'd30, 31'd127);
        add_req(CMD_DEFINITE, 2'd2, 1'b0, 31'd31, 31'd128);
        add_req(CMD_DEFINITE, 2'd3, 1'b1, 31'd127, 31'd255);
        add_req(CMD_DEFINITE, 2'd0, 1'b1, 31'd128, 31'd256);
        add_req(CMD_DEFINITE, 2'd1, 1'b0, 31'h3FFF, 31'hFFFF);
        add_req(CMD_DEFINITE, 2'd2, 1'b1, 31'h4000, 31'h1_0000);
        add_req(CMD_DEFINITE, 2'd3, 1'b0, 31'h1F_FFFF, 31'hFF_FFFF);
        add_req(CMD_DEFINITE, 2'd0, 1'b0, 31'h20_0000, 31'h100_0000);
        add_req(CMD_DEFINITE, 2'd1, 1'b1, 31'hFFF_FFFF, 31'h5555_5555);
        add_req(CMD_DEFINITE, 2'd2, 1'b0, 31'h1000_0000, 31'h2AAA_AAAA);
        add_req(CMD_DEFINITE, 2'd3, 1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_req(CMD_INDEFINITE, 2'd0, 1'b0, 31'd0, 31'h7FFF_FFFF);
        add_req(CMD_INDEFINITE, 2'd3, 1'b1, 31'd30, 31'd5);
        add_req(CMD_INDEFINITE, 2'd1, 1'b0, 31'd31, 31'd0);
        add_req(CMD_INDEFINITE, 2'd2, 1'b1, 31'h7FFF_FFFF, 31'd200);
        add_req(CMD_EOC, 2'd0, 1'b0, 31'd0, 31'd0);
        add_req(CMD_UNUSED, 2'd0, 1'b0, 31'd0, 31'd0);
        add_req(CMD_EOC, 2'd1, 1'b0, 31'h2AAA_AAAA, 31'h5555_5555);

        // Random: mostly headers, some end-of-contents, a few ignored commands
        made = 0;
        while (made < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                r.command = CMD_DEFINITE;
            else if (pick < 15)
                r.command = CMD_INDEFINITE;
            else if (pick < 18)
                r.command = CMD_EOC;
            else
                r.command = CMD_UNUSED;
            r.id_class       = 2'($urandom_range(0, 3));
            r.constructed    = 1'($urandom_range(0, 1));
            r.tag_number     = random_number(30);
            r.content_length = random_number(127);
            pending_reqs.push_back(r);
            made++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all items offered and taken, then every octet back
        while (pending_reqs.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (octets_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0 && octets_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
